// ===== rtl/core/iiea_pkg.sv =====
package iiea_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int IDX_W      = 7;
  localparam int POS_W      = IDX_W + 1;
  localparam int CAP_W      = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_GET    = 2'd2,
    REQ_SET    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_GET,
    S_DONE
  } state_t;

  typedef struct packed {
    req_type_t                     req_type;
    logic [IDX_W-1:0]              index;
    logic [IDX_W-1:0]              count;
    logic signed [DATA_WIDTH-1:0]  value;
    logic                          last_in_run;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  read_value;
    logic [IDX_W-1:0]              list_size;
    logic [CAP_W-1:0]              reported_capacity;
    status_t                       status;
  } rsp_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0]  wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/iiea_if.sv =====
interface iiea_req_if;
  import iiea_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iiea_rsp_if;
  import iiea_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/iiea_ram.sv =====
module iiea_ram (
  input  logic                             clk,
  input  iiea_pkg::ram_req_t               req,
  output logic [iiea_pkg::DATA_WIDTH-1:0]  rdata
);
  import iiea_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/core/iiea_ctrl.sv =====
module iiea_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  iiea_req_if.sink                         in_req,
  iiea_rsp_if.source                       out_rsp,
  output iiea_pkg::ram_req_t               ram_req,
  input  logic [iiea_pkg::DATA_WIDTH-1:0]  ram_rdata
);
  import iiea_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic [CNT_W-1:0]       run_off_r, run_off_nxt;
  logic                   is_ins_r, is_ins_nxt;
  logic [ADDR_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]      dst_r, dst_nxt;
  logic [ADDR_W-1:0]      wr_addr_r, wr_addr_nxt;
  logic [CNT_W-1:0]       moves_r, moves_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  rsp_t                   res_r, res_nxt;
  rsp_t                   out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_fire;
  logic                   out_free;
  logic [POS_W-1:0]       pos_w;
  logic [POS_W-1:0]       span_w;
  logic                   full;
  logic                   ins_ok, ers_ok, acc_ok;
  logic                   shift_end;

  assign in_fire   = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign shift_end = (moves_r == '0) && !rd_pend_r;

  // request checks against the current size
  always_comb begin
    pos_w  = POS_W'(in_req.data.index) + POS_W'(run_off_r);
    span_w = POS_W'(in_req.data.index) + POS_W'(in_req.data.count);
    full   = (cnt_r == CNT_W'(DEPTH));
    ins_ok = !full && (pos_w <= POS_W'(cnt_r));
    ers_ok = (span_w <= POS_W'(cnt_r));
    acc_ok = (in_req.data.index < cnt_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_req.data.req_type)
            REQ_INSERT: state_nxt = ins_ok ? S_SHIFT : S_DONE;
            REQ_ERASE:  state_nxt = ers_ok ? S_SHIFT : S_DONE;
            REQ_GET:    state_nxt = acc_ok ? S_GET : S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_SHIFT: begin
        if (shift_end) begin
          state_nxt = S_DONE;
        end
      end
      S_GET: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    cap_nxt       = cap_r;
    run_off_nxt   = run_off_r;
    is_ins_nxt    = is_ins_r;
    rd_addr_nxt   = rd_addr_r;
    dst_nxt       = dst_r;
    wr_addr_nxt   = wr_addr_r;
    moves_nxt     = moves_r;
    rd_pend_nxt   = rd_pend_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_req       = '0;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.read_value = '0;
          res_nxt.status     = ST_OK;
          // a dropped insert inside a run keeps the offset
          if (in_req.data.req_type != REQ_INSERT) begin
            run_off_nxt = '0;
          end
          case (in_req.data.req_type)
            REQ_INSERT: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else if (!ins_ok) begin
                res_nxt.status = ST_RANGE;
              end else begin
                cnt_nxt     = cnt_r + CNT_W'(1);
                // capacity was above the old size, so one doubling is enough
                if (cap_r <= CAP_W'(cnt_r + CNT_W'(1))) begin
                  cap_nxt = cap_r << 1;
                end
                run_off_nxt = run_off_r + CNT_W'(1);
                is_ins_nxt  = 1'b1;
                moves_nxt   = cnt_r - pos_w[CNT_W-1:0];
                rd_addr_nxt = ADDR_W'(cnt_r - CNT_W'(1));
                dst_nxt     = cnt_r[ADDR_W-1:0];
                pos_nxt     = pos_w[ADDR_W-1:0];
                val_nxt     = in_req.data.value;
              end
              if (in_req.data.last_in_run) begin
                run_off_nxt = '0;
              end
            end
            REQ_ERASE: begin
              if (!ers_ok) begin
                res_nxt.status = ST_RANGE;
              end else begin
                cnt_nxt     = cnt_r - in_req.data.count;
                is_ins_nxt  = 1'b0;
                moves_nxt   = (in_req.data.count == '0) ? '0 :
                              cnt_r - span_w[CNT_W-1:0];
                rd_addr_nxt = span_w[ADDR_W-1:0];
                dst_nxt     = in_req.data.index[ADDR_W-1:0];
              end
            end
            REQ_GET: begin
              if (!acc_ok) begin
                res_nxt.status = ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = in_req.data.index[ADDR_W-1:0];
              end
            end
            default: begin
              if (!acc_ok) begin
                res_nxt.status = ST_RANGE;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = in_req.data.index[ADDR_W-1:0];
                ram_req.wdata = in_req.data.value;
              end
            end
          endcase
          res_nxt.list_size         = cnt_nxt;
          res_nxt.reported_capacity = cap_nxt;
        end
      end
      S_SHIFT: begin
        rd_pend_nxt = 1'b0;
        // write back the entry read last cycle, up one or down count slots
        if (rd_pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wr_addr_r;
          ram_req.wdata = ram_rdata;
        end
        if (moves_r != '0) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_addr_r;
          rd_pend_nxt   = 1'b1;
          wr_addr_nxt   = dst_r;
          moves_nxt     = moves_r - CNT_W'(1);
          rd_addr_nxt   = is_ins_r ? rd_addr_r - ADDR_W'(1) : rd_addr_r + ADDR_W'(1);
          dst_nxt       = is_ins_r ? dst_r - ADDR_W'(1) : dst_r + ADDR_W'(1);
        end else if (!rd_pend_r && is_ins_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = val_r;
        end
      end
      S_GET: begin
        res_nxt.read_value = ram_rdata;
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_W'(1);
      run_off_r   <= '0;
      moves_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cap_r       <= cap_nxt;
      run_off_r   <= run_off_nxt;
      moves_r     <= moves_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r  <= is_ins_nxt;
    rd_addr_r <= rd_addr_nxt;
    dst_r     <= dst_nxt;
    wr_addr_r <= wr_addr_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("list size above depth");

  a_cap_above_size: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r > CAP_W'(cnt_r))
    else $error("capacity not above size");

  a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(cap_r))
    else $error("capacity not a power of two");

  a_run_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_off_r <= cnt_r)
    else $error("run offset beyond stored entries");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("shift writes the entry it reads");
`endif

endmodule

// ===== rtl/core/indexed_insert_erase_array_top.sv =====
// ordered list store of iiea_pkg::DEPTH entries with insert, erase, get and set
// in_req carries one request per transfer: req_type, index, count, value and
// last_in_run; an insert run places its elements at index plus a running offset
// out_rsp carries one result per request: read_value, list_size,
// reported_capacity and status (ok, full, out of range)
// both channels transfer when valid and ready are high at a rising edge of clk
// requests are handled one at a time; in_req.ready is high while no request is
// in progress, and a finished result may still wait in the output register
// after a request is accepted, set and failed requests go straight to S_DONE,
// get takes the read entry in S_GET, and insert and erase move entries in
// S_SHIFT, one entry read and one written back per cycle through the
// single-port read / single-port write entry memory; S_SHIFT then drains the
// last read, an insert writes its new value, and S_DONE passes the result on
// in_req.ready rises in the same cycle as out_rsp.valid, so the next request
// can be accepted while the result is still offered
// rst_n (synchronous, active low) empties the list, sets capacity to 1 and
// clears the run offset; the entry memory itself is not cleared
// when out_rsp.ready is low the result holds; one more request is accepted and
// processed, then the block waits until the held result is taken
module indexed_insert_erase_array_top (
  input  logic        clk,
  input  logic        rst_n,
  iiea_req_if.sink    in_req,
  iiea_rsp_if.source  out_rsp
);
  import iiea_pkg::*;

  ram_req_t               ram_req;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  iiea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  iiea_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule
